// ===== rtl/wesd_pkg.sv =====
package wesd_pkg;

   // field and datapath widths
   localparam int TPM_W       = 16;
   localparam int WIN_W       = 16;
   localparam int TIME_W      = 32;
   localparam int SPEED_W     = 16;
   localparam int DIST_W      = 32;
   localparam int WIN_CNT_W   = 16;
   localparam int TOTAL_W     = 32;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   // serial multiplier: elapsed time times ticks per meter
   localparam int MUL_A_W   = TIME_W;
   localparam int MUL_B_W   = TPM_W;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // serial divider: numerator fits 40 bits, denominator up to the product width
   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = MUL_P_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // scale constants
   localparam logic [TPM_W-1:0] TPM_RESET   = 16'd100;
   localparam logic [WIN_W-1:0] WIN_RESET   = 16'd1000;
   localparam int               SPEED_SCALE = 100000;
   localparam int               DIST_SCALE  = 200;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TICKS_PER_METER = 1'b0,
      CSR_WINDOW_MS       = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              pin_level;
      logic [TIME_W-1:0] time_ms;
   } req_word_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_cm_per_s;
      logic [DIST_W-1:0]  distance_cm;
      logic               window_closed;
   } rsp_word_type;

endpackage

// ===== rtl/wesd_mul.sv =====
module wesd_mul
   import wesd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] mcand,
   input  logic [MUL_B_W-1:0] mplier,
   output logic               done,
   output logic [MUL_P_W-1:0] prod
);

   logic [MUL_P_W-1:0]   acc_ff, acc_in;
   logic [MUL_P_W-1:0]   mc_ff, mc_in;
   logic [MUL_B_W-1:0]   mp_ff, mp_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   // one multiplier bit per cycle, shift-add
   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mc_in   = MUL_P_W'(mcand);
         mp_in   = mplier;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in  = mc_ff << 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== rtl/wesd_div.sv =====
module wesd_div
   import wesd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quot
);

   logic [DIV_NUM_W-1:0] q_ff, q_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W:0]   rem_sub;
   logic                 fits;

   // restoring division, one quotient bit per cycle; numerator shifts out
   // of the quotient register as quotient bits shift in
   always_comb begin
      rem_sh  = {rem_ff, q_ff[DIV_NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      fits    = rem_sh >= {1'b0, den_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         q_in   = {q_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== rtl/wheel_encoder_speed_distance.sv =====
// A word that closes a window runs a serial multiply, then two divisions
// (speed, then distance); any other word runs the distance division alone.
// One word at a time: the input stalls from an accepted word until its result
// sits in the output register, which waits while an earlier result is stalled.
// Reset (synchronous, active high): counters, window start and speed clear;
// ticks per meter returns to 100 and the window length to 1000 ms.
module wheel_encoder_speed_distance
   import wesd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_DSPD = 5'b00100,
      S_DDST = 5'b01000,
      S_LOAD = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [TPM_W-1:0]     tpm_ff;
   logic [WIN_W-1:0]     win_ff;
   logic                 last_level_ff, last_level_in;
   logic [WIN_CNT_W-1:0] wticks_ff, wticks_in;
   logic [WIN_CNT_W-1:0] wsnap_ff, wsnap_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [TIME_W-1:0]    wstart_ff, wstart_in;
   logic [TIME_W-1:0]    elapsed_ff, elapsed_in;
   logic [SPEED_W-1:0]   speed_ff, speed_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic                 closed_ff, closed_in;
   logic                 mul_go_ff, mul_go_in;
   logic                 div_go_ff, div_go_in;
   logic                 div_dist_ff, div_dist_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_data_ff, rsp_data_in;

   logic                 req_acc;
   logic                 rise;
   logic [WIN_CNT_W-1:0] wticks_cnt;
   logic [TOTAL_W-1:0]   total_cnt;
   logic [TIME_W-1:0]    elapsed;
   logic                 closes;
   logic [TPM_W-1:0]     tpm_eff;
   logic [DIV_NUM_W-1:0] speed_num;
   logic [DIV_NUM_W-1:0] dist_num;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 mul_done;
   logic [MUL_P_W-1:0]   mul_prod;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quot;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff <= TPM_RESET;
         win_ff <= WIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TICKS_PER_METER: tpm_ff <= csr_wdata[TPM_W-1:0];
            CSR_WINDOW_MS:       win_ff <= csr_wdata[WIN_W-1:0];
            default:             ;
         endcase
      end
   end

   // a zero stripe count behaves as one
   assign tpm_eff = (tpm_ff == '0) ? TPM_W'(1) : tpm_ff;

   // edge detect, saturating counts and window test for an incoming word
   assign req_acc    = req_valid && !req_stall;
   assign rise       = !last_level_ff && req_data.pin_level;
   assign wticks_cnt = (rise && wticks_ff != '1) ? wticks_ff + 1'b1 : wticks_ff;
   assign total_cnt  = (rise && total_ff != '1) ? total_ff + 1'b1 : total_ff;
   assign elapsed    = req_data.time_ms - wstart_ff;
   assign closes     = elapsed > TIME_W'(win_ff);

   // divider operands: speed or distance
   assign speed_num = DIV_NUM_W'(wsnap_ff) * DIV_NUM_W'(SPEED_SCALE);
   assign dist_num  = DIV_NUM_W'(total_ff) * DIV_NUM_W'(DIST_SCALE) + DIV_NUM_W'(tpm_eff);
   assign div_num   = div_dist_ff ? dist_num : speed_num;
   assign div_den   = div_dist_ff ? DIV_DEN_W'({tpm_eff, 1'b0}) : mul_prod;

   wesd_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_go_ff),
      .mcand  (elapsed_ff),
      .mplier (tpm_eff),
      .done   (mul_done),
      .prod   (mul_prod)
   );

   wesd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      last_level_in = last_level_ff;
      wticks_in     = wticks_ff;
      wsnap_in      = wsnap_ff;
      total_in      = total_ff;
      wstart_in     = wstart_ff;
      elapsed_in    = elapsed_ff;
      speed_in      = speed_ff;
      dist_in       = dist_ff;
      closed_in     = closed_ff;
      mul_go_in     = 1'b0;
      div_go_in     = 1'b0;
      div_dist_in   = div_dist_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               last_level_in = req_data.pin_level;
               total_in      = total_cnt;
               wsnap_in      = wticks_cnt;
               elapsed_in    = elapsed;
               closed_in     = closes;
               if (closes) begin
                  wticks_in = '0;
                  wstart_in = req_data.time_ms;
                  mul_go_in = 1'b1;
                  state_in  = S_MUL;
               end else begin
                  wticks_in   = wticks_cnt;
                  div_go_in   = 1'b1;
                  div_dist_in = 1'b1;
                  state_in    = S_DDST;
               end
            end
         end
         S_MUL: begin
            if (mul_done) begin
               div_go_in   = 1'b1;
               div_dist_in = 1'b0;
               state_in    = S_DSPD;
            end
         end
         S_DSPD: begin
            if (div_done) begin
               speed_in    = (|div_quot[DIV_NUM_W-1:SPEED_W]) ? '1 : div_quot[SPEED_W-1:0];
               div_go_in   = 1'b1;
               div_dist_in = 1'b1;
               state_in    = S_DDST;
            end
         end
         S_DDST: begin
            if (div_done) begin
               dist_in  = (|div_quot[DIV_NUM_W-1:DIST_W]) ? '1 : div_quot[DIST_W-1:0];
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.speed_cm_per_s = speed_ff;
               rsp_data_in.distance_cm    = dist_ff;
               rsp_data_in.window_closed  = closed_ff;
               state_in                   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_level_ff <= 1'b0;
         wticks_ff     <= '0;
         total_ff      <= '0;
         wstart_ff     <= '0;
         speed_ff      <= '0;
         mul_go_ff     <= 1'b0;
         div_go_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_level_ff <= last_level_in;
         wticks_ff     <= wticks_in;
         total_ff      <= total_in;
         wstart_ff     <= wstart_in;
         speed_ff      <= speed_in;
         mul_go_ff     <= mul_go_in;
         div_go_ff     <= div_go_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wsnap_ff    <= wsnap_in;
      elapsed_ff  <= elapsed_in;
      dist_ff     <= dist_in;
      closed_ff   <= closed_in;
      div_dist_ff <= div_dist_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/wesd_checker.sv =====
module wesd_checker
   import wesd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   logic               rsp_acc;
   logic [SPEED_W-1:0] last_speed_ff;

   assign rsp_acc = rsp_valid && !rsp_stall;

   // track the speed of the last delivered word
   always_ff @(posedge clock) begin
      if (reset) begin
         last_speed_ff <= '0;
      end else if (rsp_acc) begin
         last_speed_ff <= rsp_data.speed_cm_per_s;
      end
   end

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // an accepted word keeps the input side busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again without processing");

   // speed only moves on a word that closes a window
   a_speed_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !rsp_data.window_closed |-> rsp_data.speed_cm_per_s == last_speed_ff)
      else $error("speed changed without a window close");

   // the output register comes out of reset empty
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

endmodule

bind wheel_encoder_speed_distance wesd_checker u_wesd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
